FILE: hw/rtl/text_console_char_writer_defines.svh
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// same-cycle implication on clk, off while arst_n is low
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while arst_n is low
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int OPQ_DEPTH   = 2;
	localparam int RESQ_DEPTH  = 2;
	localparam int TAB_STOP    = 8;

	localparam logic [15:0] BLANK_CELL = 16'h0F20;
	localparam logic [7:0]  ATTR_RESET = 8'h03;

	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_FF       = 8'h0C;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7F;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_PRINT,
		OP_BS,
		OP_TAB,
		OP_CR,
		OP_LF,
		OP_FF,
		OP_READ,
		OP_READ_OOR
	} op_kind_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_location;
	} res_t;

endpackage

FILE: hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/tcw_fifo.sv
`timescale 1ns / 1ps

module tcw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

FILE: hw/rtl/tcw_front.sv
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	localparam int CELL_W = $clog2(COLUMNS * ROWS),
	localparam int OP_W   = $bits(op_kind_t) + 8 + CELL_W
) (
	input  logic            push,
	output logic            full,
	input  logic            cmd,
	input  logic [7:0]      char_code,
	input  logic [10:0]     read_address,
	input  logic            busy,
	input  logic            q_full,
	output logic            q_push,
	output logic [OP_W-1:0] q_op
);

	localparam int CELLS = COLUMNS * ROWS;

	op_kind_t kind;

	always_comb begin
		if (cmd) begin
			kind = (32'(read_address) < CELLS) ? OP_READ : OP_READ_OOR;
		end else begin
			unique case (char_code)
				CH_BS:   kind = OP_BS;
				CH_TAB:  kind = OP_TAB;
				CH_LF:   kind = OP_LF;
				CH_FF:   kind = OP_FF;
				CH_CR:   kind = OP_CR;
				default: kind = (char_code >= CH_PRINT_LO && char_code <= CH_PRINT_HI) ?
					OP_PRINT : OP_NOP;
			endcase
		end
	end

	assign full   = q_full | busy;
	assign q_push = push & ~full;
	assign q_op   = {kind, char_code, CELL_W'(read_address)};

endmodule

FILE: hw/rtl/tcw_engine.sv
`timescale 1ns / 1ps

module tcw_engine import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	localparam int CELL_W = $clog2(COLUMNS * ROWS),
	localparam int OP_W   = $bits(op_kind_t) + 8 + CELL_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  logic [OP_W-1:0] op_data,
	output logic            op_pop,
	input  logic            res_full,
	output logic            res_push,
	output res_t            res_data,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data,
	output logic            busy
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int SUM_W  = CELL_W + 1;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COLX_W = COL_W + 1;
	localparam int ROWX_W = ROW_W + 1;
	localparam int KIND_W = $bits(op_kind_t);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCROLL = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t            state_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] base_q;
	logic [CELL_W-1:0] sweep_q;
	logic [7:0]        attr_q;
	logic              init_q;
	logic              rd_sel_q;

	op_kind_t          op_kind;
	logic [7:0]        op_char;
	logic [CELL_W-1:0] op_addr;

	logic [CELL_W-1:0] cur_loc;
	logic [COLX_W-1:0] colx;
	logic [ROWX_W-1:0] rowx;
	logic              put_we;
	logic [CELL_W-1:0] put_lg;
	logic [7:0]        put_char;
	logic              wrap;
	logic              scroll;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic              dispatch;
	logic [CELL_W-1:0] scroll_last;
	logic [CELL_W-1:0] base_next;

	logic              ram_we;
	logic [CELL_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [CELL_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	// logical cell index to physical, rows rotate by base_q on scroll
	function automatic logic [CELL_W-1:0] to_phys(input logic [CELL_W-1:0] lg,
	                                              input logic [CELL_W-1:0] base);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, lg} + {1'b0, base};
		if (sum >= SUM_W'(CELLS)) begin
			sum = sum - SUM_W'(CELLS);
		end
		return sum[CELL_W-1:0];
	endfunction

	assign op_kind = op_kind_t'(op_data[CELL_W + 8 +: KIND_W]);
	assign op_char = op_data[CELL_W +: 8];
	assign op_addr = op_data[CELL_W-1:0];

	assign cur_loc     = CELL_W'(CELL_W'(row_q) * CELL_W'(COLUMNS)) + CELL_W'(col_q);
	assign scroll_last = base_q + CELL_W'(COLUMNS - 1);
	assign base_next   = (base_q == CELL_W'(CELLS - COLUMNS)) ? '0 : base_q + CELL_W'(COLUMNS);
	assign dispatch    = (state_q == ST_IDLE) && op_valid && !res_full;
	assign op_pop      = dispatch;
	assign busy        = init_q;

	always_comb begin
		colx     = COLX_W'(col_q);
		rowx     = ROWX_W'(row_q);
		put_we   = 1'b0;
		put_lg   = cur_loc;
		put_char = op_char;
		unique case (op_kind)
			OP_PRINT: begin
				put_we = 1'b1;
				colx   = COLX_W'(col_q) + 1'b1;
			end
			OP_BS: begin
				if (col_q != '0) begin
					put_we   = 1'b1;
					colx     = COLX_W'(col_q) - 1'b1;
					put_lg   = cur_loc - 1'b1;
					put_char = CH_SPACE;
				end
			end
			OP_TAB: colx = (COLX_W'(col_q) + COLX_W'(TAB_STOP)) & ~COLX_W'(TAB_STOP - 1);
			OP_CR:  colx = '0;
			OP_LF: begin
				colx = '0;
				rowx = ROWX_W'(row_q) + 1'b1;
			end
			default: begin
			end
		endcase
		wrap = (colx >= COLX_W'(COLUMNS));
		if (wrap) begin
			colx = '0;
			rowx = rowx + 1'b1;
		end
		scroll = (rowx >= ROWX_W'(ROWS));
		col_n  = COL_W'(colx);
		row_n  = scroll ? ROW_W'(ROWS - 1) : ROW_W'(rowx);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = BLANK_CELL;
		ram_re    = 1'b0;
		ram_raddr = to_phys(op_addr, base_q);
		unique case (state_q)
			ST_CLEAR, ST_SCROLL: ram_we = 1'b1;
			ST_IDLE: begin
				if (dispatch) begin
					ram_re    = (op_kind == OP_READ);
					ram_we    = put_we;
					ram_waddr = to_phys(put_lg, base_q);
					ram_wdata = {attr_q, put_char};
				end
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			col_q    <= '0;
			row_q    <= '0;
			base_q   <= '0;
			sweep_q  <= '0;
			attr_q   <= ATTR_RESET;
			init_q   <= 1'b1;
			rd_sel_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sweep_q == CELL_W'(CELLS - 1)) begin
						base_q  <= '0;
						col_q   <= '0;
						row_q   <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RESP;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (dispatch) begin
						rd_sel_q <= (op_kind == OP_READ);
						if (op_kind == OP_FF) begin
							sweep_q <= '0;
							state_q <= ST_CLEAR;
						end else if (op_kind == OP_READ || op_kind == OP_READ_OOR) begin
							state_q <= ST_RESP;
						end else begin
							col_q <= col_n;
							row_q <= row_n;
							if (scroll) begin
								sweep_q <= base_q;
								state_q <= ST_SCROLL;
							end else begin
								state_q <= ST_RESP;
							end
						end
					end
				end
				ST_SCROLL: begin
					if (sweep_q == scroll_last) begin
						base_q  <= base_next;
						state_q <= ST_RESP;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_RESP: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_push                 = (state_q == ST_RESP);
	assign res_data.read_data       = rd_sel_q ? ram_rdata : 16'h0000;
	assign res_data.cursor_column   = 7'(col_q);
	assign res_data.cursor_row      = 5'(row_q);
	assign res_data.cursor_location = 11'(cur_loc);

endmodule

FILE: hw/rtl/text_console_char_writer.sv
`timescale 1ns / 1ps
// An accepted item passes the operation queue, the engine's response state and the
// result queue before its result is on the output. The engine takes no new item
// until it has answered the last; a put that scrolls also blanks the freed row, a
// form feed sweeps the screen RAM, which has one write port. Up to 2 items queue
// ahead of the engine. Reset: arst_n asynchronous, active low; after release the
// screen RAM is swept to blank with full held high.

module text_console_char_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [7:0]  char_code,
	input  logic [10:0] read_address,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] read_data,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_location,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int CELL_W = $clog2(COLUMNS * ROWS);
	localparam int OP_W   = $bits(op_kind_t) + 8 + CELL_W;

	logic            busy;
	logic            opq_full;
	logic            opq_empty;
	logic            opq_push;
	logic            opq_pop;
	logic [OP_W-1:0] opq_wdata;
	logic [OP_W-1:0] opq_rdata;
	logic            resq_full;
	logic            resq_push;
	res_t            resq_wdata;
	res_t            resq_rdata;

	assign cfg_ready = 1'b1;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.char_code    (char_code),
		.read_address (read_address),
		.busy         (busy),
		.q_full       (opq_full),
		.q_push       (opq_push),
		.q_op         (opq_wdata)
	);

	tcw_fifo #(
		.WIDTH(OP_W),
		.DEPTH(OPQ_DEPTH)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (opq_push),
		.wdata  (opq_wdata),
		.pop    (opq_pop),
		.full   (opq_full),
		.empty  (opq_empty),
		.rdata  (opq_rdata)
	);

	tcw_engine #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (~opq_empty),
		.op_data  (opq_rdata),
		.op_pop   (opq_pop),
		.res_full (resq_full),
		.res_push (resq_push),
		.res_data (resq_wdata),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.busy     (busy)
	);

	tcw_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (resq_push),
		.wdata  (resq_wdata),
		.pop    (pop),
		.full   (resq_full),
		.empty  (empty),
		.rdata  (resq_rdata)
	);

	assign read_data       = resq_rdata.read_data;
	assign cursor_column   = resq_rdata.cursor_column;
	assign cursor_row      = resq_rdata.cursor_row;
	assign cursor_location = resq_rdata.cursor_location;

endmodule

FILE: hw/rtl/tcw_checker.sv
`timescale 1ns / 1ps
`include "text_console_char_writer_defines.svh"

module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [15:0] read_data,
	input logic [6:0]  cursor_column,
	input logic [4:0]  cursor_row,
	input logic [10:0] cursor_location
);

	// items accepted whose result transaction has not completed
	logic [3:0] out_cnt_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = push & ~full;
	assign out_acc = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else begin
			out_cnt_q <= out_cnt_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	`TCW_ASSERT_NOW(a_result_has_item, !empty, out_cnt_q != 4'd0, "result with no item pending")
	`TCW_ASSERT_NEXT(a_last_result_drains, out_acc && out_cnt_q == 4'd1, empty, "extra result")
	`TCW_ASSERT_NOW(a_cursor_bounds, !empty, (32'(cursor_column) < COLUMNS) && (32'(cursor_row) < ROWS), "cursor off screen")
	`TCW_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(read_data) && $stable(cursor_location), "result changed while stalled")

endmodule

bind text_console_char_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_checker (.*);

FILE: sim/text_console_char_writer_test.sv
`timescale 1ns / 1ps

module text_console_char_writer_test import tcw_pkg::*; ();

	localparam int COLS  = COLUMNS_DEF;
	localparam int LINES = ROWS_DEF;
	localparam int CELLS = COLS * LINES;

	localparam bit CMD_PUT  = 1'b0;
	localparam bit CMD_READ = 1'b1;

	localparam int IDLE_PCT = 16;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        cmd;
	logic [7:0]  char_code;
	logic [10:0] read_address;
	logic        empty;
	logic        pop;
	logic [15:0] read_data;
	logic [6:0]  cursor_column;
	logic [4:0]  cursor_row;
	logic [10:0] cursor_location;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	text_console_char_writer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.cmd             (cmd),
		.char_code       (char_code),
		.read_address    (read_address),
		.empty           (empty),
		.pop             (pop),
		.read_data       (read_data),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cursor_location (cursor_location),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	// shadow copy of the console
	logic [15:0] shadow_screen [0:CELLS-1];
	int          shadow_col;
	int          shadow_row;
	logic [7:0]  shadow_attr;

	res_t        pending_results [$];
	res_t        want;
	bit          quiet;
	int          mismatches;
	int          results_checked;
	int          puts_sent;
	int          reads_sent;
	int          scrolls_seen;
	int          clears_seen;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("status: fail");
		$finish;
	end

	function automatic void blank_rows(int first, int last);
		for (int i = first; i < last; i++)
			shadow_screen[i] = BLANK_CELL;
	endfunction

	function automatic res_t next_console_result(bit op, logic [7:0] code, logic [10:0] addr);
		res_t r;
		int   loc;
		r.read_data = '0;
		if (op == CMD_READ) begin
			if (addr < CELLS)
				r.read_data = shadow_screen[addr];
		end else begin
			case (code)
				CH_BS: begin
					if (shadow_col != 0) begin
						shadow_col--;
						shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, CH_SPACE};
					end
				end
				CH_TAB: shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
				CH_CR:  shadow_col = 0;
				CH_LF: begin
					shadow_row++;
					shadow_col = 0;
				end
				CH_FF: begin
					blank_rows(0, CELLS);
					shadow_col = 0;
					shadow_row = 0;
					clears_seen++;
				end
				default: begin
					if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
						shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, code};
						shadow_col++;
					end
				end
			endcase
			if (shadow_col >= COLS) begin
				shadow_row++;
				shadow_col = 0;
			end
			if (shadow_row >= LINES) begin
				for (int i = 0; i < CELLS - COLS; i++)
					shadow_screen[i] = shadow_screen[i + COLS];
				blank_rows(CELLS - COLS, CELLS);
				shadow_row = LINES - 1;
				scrolls_seen++;
			end
		end
		loc = shadow_row * COLS + shadow_col;
		r.cursor_column   = shadow_col[6:0];
		r.cursor_row      = shadow_row[4:0];
		r.cursor_location = loc[10:0];
		return r;
	endfunction

	// result side: random back-pressure
	always @(posedge clk) begin
		pop <= arst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, read_data);
					mismatches++;
				end
				if (cursor_column !== want.cursor_column) begin
					$error("cursor_column: expected %0d, got %0d",
						want.cursor_column, cursor_column);
					mismatches++;
				end
				if (cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row, cursor_row);
					mismatches++;
				end
				if (cursor_location !== want.cursor_location) begin
					$error("cursor_location: expected %0d, got %0d",
						want.cursor_location, cursor_location);
					mismatches++;
				end
			end
		end
	end

	task automatic send_item(input bit op, input logic [7:0] code, input logic [10:0] addr);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		cmd          <= op;
		char_code    <= code;
		read_address <= addr;
		do @(posedge clk); while (full);
		pending_results.push_back(next_console_result(op, code, addr));
		if (op == CMD_READ)
			reads_sent++;
		else
			puts_sent++;
	endtask

	task automatic put_char(input logic [7:0] code);
		send_item(CMD_PUT, code, 11'($urandom_range(2047)));
	endtask

	task automatic read_cell(input logic [10:0] addr);
		send_item(CMD_READ, 8'($urandom_range(255)), addr);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_attribute(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		shadow_attr = value;
	endtask

	task automatic test_after_reset();
		read_cell(11'd0);
		read_cell(11'(CELLS - 1));
		read_cell(11'(CELLS));
		read_cell(11'h7FF);
	endtask

	task automatic test_printable();
		put_char(CH_PRINT_LO);
		put_char(CH_PRINT_HI);
		put_char(8'h41);
		read_cell(11'd1);
	endtask

	task automatic test_control_codes();
		put_char(CH_BS);
		read_cell(11'd2);
		put_char(CH_CR);
		put_char(CH_BS);
		put_char(CH_TAB);
		put_char(CH_TAB);
		put_char(CH_LF);
		put_char(8'h00);
		put_char(8'h1F);
		put_char(8'h0B);
		put_char(8'h80);
		put_char(8'hFF);
		put_char(8'h5A);
		read_cell(11'(COLS));
		put_char(CH_FF);
		read_cell(11'd0);
	endtask

	function automatic logic [7:0] random_put_code(int lf_permille);
		int r;
		r = $urandom_range(999);
		if (r < 4)
			return CH_FF;
		r -= 4;
		if (r < lf_permille)
			return CH_LF;
		r -= lf_permille;
		if (r < 20)
			return CH_CR;
		r -= 20;
		if (r < 40)
			return CH_TAB;
		r -= 40;
		if (r < 50)
			return CH_BS;
		r -= 50;
		if (r < 60)
			return $urandom_range(1) ? 8'($urandom_range(8'h1F)) :
				8'($urandom_range(8'h80, 8'hFF));
		return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
	endfunction

	task automatic test_random_traffic(input int count, input int lf_permille);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick >= 25)
				put_char(random_put_code(lf_permille));
			else if (pick < 2)
				read_cell(11'($urandom_range(CELLS, 2047)));
			else if (pick < 14)
				read_cell(11'(shadow_row * COLS + $urandom_range(COLS - 1)));
			else
				read_cell(11'($urandom_range(CELLS - 1)));
		end
	endtask

	initial begin
		logic [7:0] attrs [4];
		arst_n       = 1'b0;
		push         = 1'b0;
		cmd          = 1'b0;
		char_code    = '0;
		read_address = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		quiet        = 1'b0;
		blank_rows(0, CELLS);
		shadow_col  = 0;
		shadow_row  = 0;
		shadow_attr = ATTR_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_printable();
		wait_idle();
		write_attribute(8'hFF);
		test_control_codes();

		attrs[0] = 8'h00;
		attrs[1] = 8'h5A;
		attrs[2] = 8'($urandom_range(255));
		attrs[3] = 8'hA5;
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_attribute(attrs[p]);
			quiet = (p == 2);
			// p == 1 keeps line feeds rare so lines wrap at the right edge
			test_random_traffic(400, (p == 1) ? 5 : 100);
		end
		quiet = 1'b0;

		wait_idle();
		repeat (40) @(posedge clk);

		$display("%0d puts and %0d reads, %0d results checked, %0d mismatches",
			puts_sent, reads_sent, results_checked, mismatches);
		$display("%0d scrolls and %0d screen clears under 6 attribute settings",
			scrolls_seen, clears_seen);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
